### rtl/assert_macros.svh
// Assertion macros used by the core RTL file of the back-edge detector.
// No dependencies; define NO_ASSERTIONS to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/dfsbe_pkg.sv
// Shared constants and types for the DFS back-edge detector.
// No dependencies; imported by the adjacency store and the core.
package dfsbe_pkg;

    localparam int NODE_W         = 4;
    localparam int MAX_NODES      = 1 << NODE_W;
    localparam int MAX_BACK_EDGES = 64;
    localparam int CFG_W          = 5;
    localparam int CNT_W          = $clog2(MAX_NODES + 1);
    localparam int BE_CNT_W       = $clog2(MAX_BACK_EDGES + 1);

    typedef logic [MAX_NODES-1:0] row_t;

    // Request into the adjacency store: one row read per cycle, optionally
    // tagged as an edge load that sets one bit of the row read.
    typedef struct packed {
        logic              rd_en;
        logic [NODE_W-1:0] rd_addr;
        logic              ld_edge;
        logic [NODE_W-1:0] ld_to;
        logic              clear;
    } adj_req_t;

    // One saved search frame: node, next neighbor to scan, its adjacency row.
    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [CNT_W-1:0]  cursor;
        row_t              row;
    } frame_t;

endpackage

### rtl/dfsbe_adj_mem.sv
// Adjacency store: one row per source node in a synchronous RAM.
// Depends on dfsbe_pkg; per-row valid bits stand in for a clear.
module dfsbe_adj_mem import dfsbe_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  adj_req_t req,
    output row_t     rd_row
);

    row_t                adj_mem [MAX_NODES];
    logic [MAX_NODES-1:0] row_vld_reg;
    row_t                rd_data_reg;
    logic                rd_vld_reg;

    // write-back stage of an edge load
    logic                ld_vld_reg;
    logic [NODE_W-1:0]   ld_row_reg;
    logic [NODE_W-1:0]   ld_col_reg;

    // last row written, forwarded to a load of the same row that directly follows
    logic                lw_vld_reg;
    logic [NODE_W-1:0]   lw_addr_reg;
    row_t                lw_data_reg;

    row_t                rd_masked;
    row_t                wr_data;

    assign rd_masked = rd_vld_reg ? rd_data_reg : '0;
    assign wr_data   = ((lw_vld_reg && (lw_addr_reg == ld_row_reg)) ? lw_data_reg : rd_masked)
                     | (row_t'(1) << ld_col_reg);
    assign rd_row    = rd_masked;

    always_ff @(posedge aclk) begin
        if (ld_vld_reg) begin
            adj_mem[ld_row_reg] <= wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= adj_mem[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            ld_row_reg <= req.rd_addr;
            ld_col_reg <= req.ld_to;
        end
        if (ld_vld_reg) begin
            lw_addr_reg <= ld_row_reg;
            lw_data_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
            ld_vld_reg  <= 1'b0;
            lw_vld_reg  <= 1'b0;
        end else begin
            ld_vld_reg <= req.rd_en && req.ld_edge;
            if (req.rd_en) begin
                rd_vld_reg <= row_vld_reg[req.rd_addr];
            end
            if (req.clear) begin
                row_vld_reg <= '0;
                lw_vld_reg  <= 1'b0;
            end else if (ld_vld_reg) begin
                row_vld_reg[ld_row_reg] <= 1'b1;
                lw_vld_reg              <= 1'b1;
            end
        end
    end

endmodule

### rtl/dfs_back_edge_detector_core.sv
// DFS back-edge detector: edges load at one transfer per cycle (RMW on the adjacency RAM).
// The transfer marked last_edge starts a search over n nodes that scans one adjacency bit
// per cycle, with one RAM wait per push or pop; a full output register that is not taken
// holds the scan. No input is taken during it.
// Synchronous active-low reset: node_count to 16, graph empty, all colors white.
// Depends on dfsbe_pkg, dfsbe_adj_mem and assert_macros.svh.
`include "assert_macros.svh"

module dfs_back_edge_detector_core import dfsbe_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [NODE_W-1:0] s_edge_from,
    input  logic [NODE_W-1:0] s_edge_to,
    input  logic              s_edge_valid,
    input  logic              s_last_edge,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [NODE_W-1:0] m_from_node,
    output logic [NODE_W-1:0] m_to_node,
    output logic              m_found,
    output logic              m_overflow,
    output logic              m_last
);

    // Search sequencer states
    localparam logic [2:0] ST_IDLE    = 3'd0;  // take edge transfers
    localparam logic [2:0] ST_START   = 3'd1;  // let the final edge write back
    localparam logic [2:0] ST_ROOT    = 3'd2;  // look for the next white root
    localparam logic [2:0] ST_ROWWAIT = 3'd3;  // adjacency row of new top arrives
    localparam logic [2:0] ST_SCAN    = 3'd4;  // test one neighbor per cycle unless the output holds it
    localparam logic [2:0] ST_POPWAIT = 3'd5;  // saved frame arrives from stack RAM
    localparam logic [2:0] ST_FINISH  = 3'd6;  // emit the closing record

    logic [2:0]          state_reg, state_next;
    logic [CFG_W-1:0]    node_count_reg;
    logic [CNT_W-1:0]    root_reg, root_next;
    logic [NODE_W-1:0]   top_reg, top_next;
    logic [CNT_W-1:0]    cur_reg, cur_next;
    row_t                top_row_reg, top_row_next;
    logic [CNT_W-1:0]    depth_reg, depth_next;
    logic [MAX_NODES-1:0] grey_reg, grey_next;
    logic [MAX_NODES-1:0] black_reg, black_next;
    logic [BE_CNT_W-1:0] cnt_reg, cnt_next;

    // Held back-edge record: only sent once we know whether another follows
    logic                pend_vld_reg, pend_vld_next;
    logic [NODE_W-1:0]   pend_from_reg, pend_from_next;
    logic [NODE_W-1:0]   pend_to_reg, pend_to_next;

    // Output register
    logic                m_valid_reg;
    logic [NODE_W-1:0]   m_from_reg, m_to_reg;
    logic                m_found_reg, m_ovf_reg, m_last_reg;
    logic                out_load;
    logic [NODE_W-1:0]   out_from, out_to;
    logic                out_found, out_ovf, out_last;
    logic                out_free;

    // Stack RAM of saved frames below the top
    frame_t              stk_mem [MAX_NODES];
    frame_t              stk_rd_reg;
    frame_t              stk_wdata;
    logic                stk_we, stk_re;
    logic [NODE_W-1:0]   stk_waddr, stk_raddr;

    adj_req_t            adj_req;
    row_t                adj_row;

    logic [CNT_W-1:0]    n_eff;
    logic [NODE_W-1:0]   j_idx, root_idx;
    logic [CNT_W-1:0]    depth_m1, depth_m2;
    logic                cur_done, hit, j_grey, j_white, root_white;
    logic                clear_run;
    logic                run_clean, depth_ok;

    dfsbe_adj_mem u_adj (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (adj_req),
        .rd_row  (adj_row)
    );

    // Saturate the node count to the store size
    assign n_eff = (node_count_reg > CFG_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                        : CNT_W'(node_count_reg);

    assign j_idx      = cur_reg[NODE_W-1:0];
    assign root_idx   = root_reg[NODE_W-1:0];
    assign depth_m1   = depth_reg - 1'b1;
    assign depth_m2   = depth_reg - 2'd2;
    assign cur_done   = (cur_reg >= n_eff);
    assign hit        = top_row_reg[j_idx];
    assign j_grey     = grey_reg[j_idx];
    assign j_white    = !grey_reg[j_idx] && !black_reg[j_idx];
    assign root_white = !grey_reg[root_idx] && !black_reg[root_idx];
    assign out_free   = !m_valid_reg || m_ready;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        root_next      = root_reg;
        top_next       = top_reg;
        cur_next       = cur_reg;
        top_row_next   = top_row_reg;
        depth_next     = depth_reg;
        grey_next      = grey_reg;
        black_next     = black_reg;
        cnt_next       = cnt_reg;
        pend_vld_next  = pend_vld_reg;
        pend_from_next = pend_from_reg;
        pend_to_next   = pend_to_reg;
        out_load       = 1'b0;
        out_from       = pend_from_reg;
        out_to         = pend_to_reg;
        out_found      = 1'b1;
        out_ovf        = 1'b0;
        out_last       = 1'b0;
        stk_we         = 1'b0;
        stk_re         = 1'b0;
        stk_waddr      = depth_m1[NODE_W-1:0];
        stk_raddr      = depth_m2[NODE_W-1:0];
        stk_wdata.node   = top_reg;
        stk_wdata.cursor = cur_reg + 1'b1;
        stk_wdata.row    = top_row_reg;
        adj_req        = '0;
        clear_run      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                // every transfer reads its source row; the store merges a valid edge's bit next cycle
                adj_req.rd_en   = s_valid;
                adj_req.rd_addr = s_edge_from;
                adj_req.ld_edge = s_edge_valid;
                adj_req.ld_to   = s_edge_to;
                if (s_valid && s_last_edge) begin
                    root_next  = '0;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (root_reg >= n_eff) begin
                    state_next = ST_FINISH;
                end else if (root_white) begin
                    // open a new tree: root goes grey, fetch its row
                    grey_next[root_idx] = 1'b1;
                    top_next            = root_idx;
                    cur_next            = '0;
                    depth_next          = CNT_W'(1);
                    adj_req.rd_en       = 1'b1;
                    adj_req.rd_addr     = root_idx;
                    state_next          = ST_ROWWAIT;
                end else begin
                    root_next = root_reg + 1'b1;
                end
            end
            ST_ROWWAIT: begin
                top_row_next = adj_row;
                state_next   = ST_SCAN;
            end
            ST_POPWAIT: begin
                top_next     = stk_rd_reg.node;
                cur_next     = stk_rd_reg.cursor;
                top_row_next = stk_rd_reg.row;
                state_next   = ST_SCAN;
            end
            ST_SCAN: begin
                if (cur_done) begin
                    // top finished: turn it black and drop it
                    grey_next[top_reg]  = 1'b0;
                    black_next[top_reg] = 1'b1;
                    if (depth_reg == CNT_W'(1)) begin
                        root_next  = root_reg + 1'b1;
                        state_next = ST_ROOT;
                    end else begin
                        stk_re     = 1'b1;
                        depth_next = depth_m1;
                        state_next = ST_POPWAIT;
                    end
                end else if (hit && j_grey) begin
                    // back edge; hold the scan while the held record cannot move out
                    if (!pend_vld_reg) begin
                        pend_vld_next  = 1'b1;
                        pend_from_next = top_reg;
                        pend_to_next   = j_idx;
                        cnt_next       = cnt_reg + 1'b1;
                        cur_next       = cur_reg + 1'b1;
                    end else if (out_free) begin
                        out_load = 1'b1;
                        if (cnt_reg == BE_CNT_W'(MAX_BACK_EDGES)) begin
                            // one too many: close on the held record
                            out_ovf    = 1'b1;
                            out_last   = 1'b1;
                            clear_run  = 1'b1;
                            state_next = ST_IDLE;
                        end else begin
                            pend_from_next = top_reg;
                            pend_to_next   = j_idx;
                            cnt_next       = cnt_reg + 1'b1;
                            cur_next       = cur_reg + 1'b1;
                        end
                    end
                end else if (hit && j_white && (depth_reg < CNT_W'(MAX_NODES))) begin
                    // descend: save the current frame, neighbor becomes top
                    stk_we              = 1'b1;
                    grey_next[j_idx]    = 1'b1;
                    adj_req.rd_en       = 1'b1;
                    adj_req.rd_addr     = j_idx;
                    top_next            = j_idx;
                    cur_next            = '0;
                    depth_next          = depth_reg + 1'b1;
                    state_next          = ST_ROWWAIT;
                end else begin
                    cur_next = cur_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_last   = 1'b1;
                    if (!pend_vld_reg) begin
                        // acyclic graph
                        out_from  = '0;
                        out_to    = '0;
                        out_found = 1'b0;
                    end
                    clear_run  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (clear_run) begin
            // end of run: empty graph, all white, counters back to zero
            grey_next     = '0;
            black_next    = '0;
            cnt_next      = '0;
            pend_vld_next = 1'b0;
            depth_next    = '0;
            adj_req.clear = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            stk_rd_reg <= stk_mem[stk_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        root_reg      <= root_next;
        top_reg       <= top_next;
        cur_reg       <= cur_next;
        top_row_reg   <= top_row_next;
        pend_from_reg <= pend_from_next;
        pend_to_reg   <= pend_to_next;
        if (out_load) begin
            m_from_reg  <= out_from;
            m_to_reg    <= out_to;
            m_found_reg <= out_found;
            m_ovf_reg   <= out_ovf;
            m_last_reg  <= out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            node_count_reg <= CFG_W'(MAX_NODES);
            depth_reg      <= '0;
            grey_reg       <= '0;
            black_reg      <= '0;
            cnt_reg        <= '0;
            pend_vld_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            depth_reg    <= depth_next;
            grey_reg     <= grey_next;
            black_reg    <= black_next;
            cnt_reg      <= cnt_next;
            pend_vld_reg <= pend_vld_next;
            if (cfg_we) begin
                node_count_reg <= cfg_wdata;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_from_node = m_from_reg;
    assign m_to_node   = m_to_reg;
    assign m_found     = m_found_reg;
    assign m_overflow  = m_ovf_reg;
    assign m_last      = m_last_reg;

    assign run_clean = (cnt_reg == '0) && !pend_vld_reg && (grey_reg == '0) && (black_reg == '0);
    assign depth_ok  = (depth_reg != '0) && (depth_reg <= CNT_W'(MAX_NODES));

    // A node is never grey and black at once
    `ASSERT_ALWAYS(a_colour_excl, aclk, aresetn, (grey_reg & black_reg) == '0)
    // Between runs nothing of the search is left behind
    `ASSERT_IMPLIES(a_idle_clean, aclk, aresetn, state_reg == ST_IDLE, run_clean)
    // Scanning always has a top frame and never overruns the stack
    `ASSERT_IMPLIES(a_scan_depth, aclk, aresetn, state_reg == ST_SCAN, depth_ok)
    // The acyclic record is the closing one and never flags overflow
    `ASSERT_IMPLIES(a_acyclic_rec, aclk, aresetn, m_valid && !m_found, m_last && !m_overflow)

endmodule
